// File: hw/rtl/lut_unsharp_mask_filter_defines.svh
// ----------------------------------------------------------------------------
// LUT unsharp mask filter assertion macros
// Concurrent assertion forms used by the filter's controller.
// ----------------------------------------------------------------------------
`ifndef LUT_UNSHARP_MASK_FILTER_DEFINES_SVH
`define LUT_UNSHARP_MASK_FILTER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LUMS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define LUMS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/lums_pkg.sv
// ----------------------------------------------------------------------------
// LUT unsharp mask filter package
// Shared widths, codes, state encoding and controller interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package lums_pkg;

  // Default build limits.
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int MAX_RADIUS_DEF = 8;
  localparam int TABLE_ENTRIES  = 256;

  // Field widths.
  localparam int PIX_W      = 8;
  localparam int DIM_W      = 11;
  localparam int RAD_W      = 4;
  localparam int AMT_W      = 12;
  localparam int OP_W       = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int T_W        = 23;

  // Register reset values.
  localparam logic [DIM_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 11'd480;
  localparam logic [RAD_W-1:0] RADIUS_RESET = 4'd1;
  localparam logic [AMT_W-1:0] AMOUNT_RESET = 12'd0;

  // Saturation limit of the 8.8 result.
  localparam logic signed [T_W-1:0] T_SAT = T_W'(255 * 256);
  localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLUR_RADIUS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SHARPEN_AMOUNT = 3'd3;

  typedef enum logic [OP_W-1:0] {
    OP_TABLE_WRITE = 2'd0,
    OP_PIXEL       = 2'd1,
    OP_FLUSH       = 2'd2,
    OP_NOP         = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    DIV_SEL_POS,
    DIV_SEL_ROW,
    DIV_SEL_COL
  } div_sel_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DECODE,
    ST_PIX_WRITE,
    ST_PIX_CHECK,
    ST_K_START,
    ST_K_WAIT,
    ST_SETUP_A,
    ST_SETUP_B,
    ST_SETUP_C,
    ST_ROW_BEGIN,
    ST_TAP,
    ST_DRAIN,
    ST_H_START,
    ST_H_WAIT,
    ST_ROW_END,
    ST_V_START,
    ST_V_WAIT,
    ST_CENTER,
    ST_MULT,
    ST_RESULT
  } state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic     load_item;
    logic     tone_wr;
    logic     pix_write;
    logic     clear_counts;
    logic     div_start;
    div_sel_t div_sel;
    logic     setup_bounds;
    logic     setup_offset;
    logic     setup_rows;
    logic     row_begin;
    logic     tap_read;
    logic     row_end;
    logic     center_read;
    logic     mult;
    logic     out_load;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    op_t  op;
    logic in_full;
    logic out_all;
    logic emit_ok;
    logic div_busy;
    logic div_done;
    logic col_last;
    logic row_last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// File: hw/rtl/lums_divider.sv
// ----------------------------------------------------------------------------
// LUT unsharp mask filter divider
// Restoring unsigned divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lums_divider #(
  parameter int DIVIDEND_W = 21,
  parameter int DIVISOR_W  = 11
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  busy,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient,
  output logic [DIVISOR_W-1:0]  remainder
);

  localparam int CW = $clog2(DIVIDEND_W + 1);

  logic [DIVISOR_W-1:0] dvs;
  logic [CW-1:0]        cnt;
  logic [DIVISOR_W:0]   trial;
  logic                 ge;

  // One restoring step: shift in the next dividend bit and try a subtract.
  assign trial = {remainder, quotient[DIVIDEND_W-1]};
  assign ge    = (trial >= {1'b0, dvs});

  // Control: step count and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DIVIDEND_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: partial remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dvs       <= divisor;
    end else if (busy) begin
      quotient  <= {quotient[DIVIDEND_W-2:0], ge};
      remainder <= ge ? DIVISOR_W'(trial - {1'b0, dvs}) : DIVISOR_W'(trial);
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/lums_datapath.sv
// ----------------------------------------------------------------------------
// LUT unsharp mask filter datapath
// Configuration registers, tone table, pixel store, window sums, sharpening
// arithmetic and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lums_datapath #(
  parameter int MAX_WIDTH  = lums_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = lums_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_RADIUS = lums_pkg::MAX_RADIUS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  lums_pkg::cmd_t                   cmd,
  output lums_pkg::status_t                status,
  input  logic [lums_pkg::OP_W-1:0]        operation,
  input  logic [lums_pkg::PIX_W-1:0]       table_index,
  input  logic [lums_pkg::PIX_W-1:0]       table_value,
  input  logic [lums_pkg::PIX_W-1:0]       pixel_in,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [lums_pkg::PIX_W-1:0]       pixel_out,
  output logic                             frame_end,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lums_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lums_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import lums_pkg::*;

  localparam int CNT_W     = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int BUF_DEPTH = (2 * MAX_RADIUS + 1) * MAX_WIDTH + 2 * MAX_RADIUS + 1;
  localparam int BA_W      = $clog2(BUF_DEPTH);
  localparam int DIST_W    = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
  localparam int CMP_W     = (CNT_W > DIST_W) ? CNT_W : DIST_W;
  localparam int SUM_W     = $clog2((2 * MAX_RADIUS + 1) * 255 + 1);
  localparam int DIV_W     = (CNT_W > SUM_W) ? CNT_W : SUM_W;
  localparam int Q_W       = DIV_W + DIM_W;
  localparam int WIN_W     = RAD_W + 1;
  localparam int OFF_W     = RAD_W + DIM_W + 1;
  localparam int PROD_W    = AMT_W + PIX_W + 2;

  // Configuration registers.
  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;
  logic [RAD_W-1:0] blur_radius;
  logic [AMT_W-1:0] sharpen_amount;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= WIDTH_RESET;
      image_height   <= HEIGHT_RESET;
      blur_radius    <= RADIUS_RESET;
      sharpen_amount <= AMOUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:    image_width    <= cfg_data[DIM_W-1:0];
        CFG_IMAGE_HEIGHT:   image_height   <= cfg_data[DIM_W-1:0];
        CFG_BLUR_RADIUS:    blur_radius    <= cfg_data[RAD_W-1:0];
        CFG_SHARPEN_AMOUNT: sharpen_amount <= cfg_data[AMT_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective geometry: zero raised to one, clamped to the build limits.
  logic [DIM_W-1:0] eff_w;
  logic [DIM_W-1:0] eff_h;
  logic [RAD_W-1:0] eff_r;

  always_comb begin
    if (image_width == '0) begin
      eff_w = DIM_W'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      eff_w = DIM_W'(MAX_WIDTH);
    end else begin
      eff_w = image_width;
    end
    if (image_height == '0) begin
      eff_h = DIM_W'(1);
    end else if (32'(image_height) > MAX_HEIGHT) begin
      eff_h = DIM_W'(MAX_HEIGHT);
    end else begin
      eff_h = image_height;
    end
    if (blur_radius == '0) begin
      eff_r = RAD_W'(1);
    end else if (32'(blur_radius) > MAX_RADIUS) begin
      eff_r = RAD_W'(MAX_RADIUS);
    end else begin
      eff_r = blur_radius;
    end
  end

  // Frame size and output delay, registered off the multiplier.
  logic [2*DIM_W-1:0]     area;
  logic [RAD_W+DIM_W:0]   delay_span;
  logic [CNT_W-1:0]       n_q;
  logic [DIST_W-1:0]      d_q;

  assign area       = eff_w * eff_h;
  assign delay_span = eff_r * eff_w + eff_r;

  always_ff @(posedge clk) begin
    n_q <= CNT_W'(area);
    d_q <= DIST_W'(delay_span);
  end

  // Latched item fields.
  op_t              op_q;
  logic [PIX_W-1:0] tbl_idx_q;
  logic [PIX_W-1:0] tbl_val_q;
  logic [PIX_W-1:0] pix_q;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_q      <= op_t'(operation);
      tbl_idx_q <= table_index;
      tbl_val_q <= table_value;
      pix_q     <= pixel_in;
    end
  end

  // Tone table with registered read of the latched pixel.
  logic [PIX_W-1:0] tone_mem [TABLE_ENTRIES];
  logic [PIX_W-1:0] tone_q;

  always_ff @(posedge clk) begin
    if (cmd.tone_wr) begin
      tone_mem[tbl_idx_q] <= tbl_val_q;
    end
    tone_q <= tone_mem[pix_q];
  end

  // Frame counters and their wrapped store addresses.
  logic [CNT_W-1:0] ic;
  logic [CNT_W-1:0] oc;
  logic [BA_W-1:0]  in_addr;
  logic [BA_W-1:0]  out_addr;
  logic [CNT_W:0]   oc_plus;
  logic             last_out;

  assign oc_plus  = {1'b0, oc} + 1'b1;
  assign last_out = (oc_plus >= {1'b0, n_q});

  always_ff @(posedge clk) begin
    if (rst) begin
      ic       <= '0;
      oc       <= '0;
      in_addr  <= '0;
      out_addr <= '0;
    end else if (cmd.clear_counts || (cmd.out_load && last_out)) begin
      ic       <= '0;
      oc       <= '0;
      in_addr  <= '0;
      out_addr <= '0;
    end else if (cmd.pix_write) begin
      ic      <= ic + 1'b1;
      in_addr <= (in_addr == BA_W'(BUF_DEPTH - 1)) ? '0 : in_addr + 1'b1;
    end else if (cmd.out_load) begin
      oc       <= oc + 1'b1;
      out_addr <= (out_addr == BA_W'(BUF_DEPTH - 1)) ? '0 : out_addr + 1'b1;
    end
  end

  // Shared divider: raster position, row averages, column average.
  logic             div_busy;
  logic             div_done;
  logic [DIV_W-1:0] div_dividend;
  logic [DIM_W-1:0] div_divisor;
  logic [DIV_W-1:0] div_quo;
  logic [DIM_W-1:0] div_rem;
  logic [SUM_W-1:0] hsum;
  logic [SUM_W-1:0] vsum;
  logic [WIN_W-1:0] xcnt_q;
  logic [WIN_W-1:0] ycnt_q;

  always_comb begin
    unique case (cmd.div_sel)
      DIV_SEL_ROW: begin
        div_dividend = DIV_W'(hsum);
        div_divisor  = DIM_W'(xcnt_q);
      end
      DIV_SEL_COL: begin
        div_dividend = DIV_W'(vsum);
        div_divisor  = DIM_W'(ycnt_q);
      end
      default: begin
        div_dividend = DIV_W'(oc);
        div_divisor  = eff_w;
      end
    endcase
  end

  lums_divider #(
    .DIVIDEND_W (DIV_W),
    .DIVISOR_W  (DIM_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Window bounds around the center pixel, cut at the frame edges.
  logic [DIM_W-1:0] y_c;
  logic [DIM_W-1:0] r_ext;
  logic [DIM_W-1:0] dn_avail;
  logic [DIM_W-1:0] rt_avail;
  logic [RAD_W-1:0] dy;
  logic [RAD_W-1:0] dn;
  logic [RAD_W-1:0] dx;
  logic [RAD_W-1:0] rt;
  logic [RAD_W-1:0] dy_q;
  logic [RAD_W-1:0] dx_q;

  always_comb begin
    if (Q_W'(div_quo) >= Q_W'(eff_h)) begin
      y_c = eff_h - 1'b1;
    end else begin
      y_c = DIM_W'(div_quo);
    end
    r_ext    = DIM_W'(eff_r);
    dn_avail = eff_h - 1'b1 - y_c;
    rt_avail = eff_w - 1'b1 - div_rem;
    dy = (y_c >= r_ext)      ? eff_r : RAD_W'(y_c);
    dn = (dn_avail >= r_ext) ? eff_r : RAD_W'(dn_avail);
    dx = (div_rem >= r_ext)  ? eff_r : RAD_W'(div_rem);
    rt = (rt_avail >= r_ext) ? eff_r : RAD_W'(rt_avail);
  end

  always_ff @(posedge clk) begin
    if (cmd.setup_bounds) begin
      dy_q   <= dy;
      dx_q   <= dx;
      ycnt_q <= WIN_W'(dy) + WIN_W'(dn) + 1'b1;
      xcnt_q <= WIN_W'(dx) + WIN_W'(rt) + 1'b1;
    end
  end

  // Distance from the center back to the window's first tap.
  logic [OFF_W-1:0] off_prod;
  logic [BA_W-1:0]  offset_q;

  assign off_prod = OFF_W'(dy_q) * OFF_W'(eff_w) + OFF_W'(dx_q);

  always_ff @(posedge clk) begin
    if (cmd.setup_offset) begin
      offset_q <= BA_W'(off_prod);
    end
  end

  // Row and column walk through the circular pixel store.
  logic [BA_W-1:0]  row_addr;
  logic [BA_W-1:0]  col_addr;
  logic [BA_W:0]    row_sum;
  logic [BA_W-1:0]  row_next;
  logic [WIN_W-1:0] rows_left;
  logic [WIN_W-1:0] cols_left;

  assign row_sum  = {1'b0, row_addr} + (BA_W+1)'(eff_w);
  assign row_next = (row_sum >= (BA_W+1)'(BUF_DEPTH)) ?
                    BA_W'(row_sum - (BA_W+1)'(BUF_DEPTH)) : BA_W'(row_sum);

  always_ff @(posedge clk) begin
    if (cmd.setup_rows) begin
      if (out_addr >= offset_q) begin
        row_addr <= out_addr - offset_q;
      end else begin
        row_addr <= BA_W'((BA_W+1)'(out_addr) + (BA_W+1)'(BUF_DEPTH)
                          - (BA_W+1)'(offset_q));
      end
      rows_left <= ycnt_q;
    end else if (cmd.row_end) begin
      row_addr  <= row_next;
      rows_left <= rows_left - 1'b1;
    end
    if (cmd.row_begin) begin
      col_addr  <= row_addr;
      cols_left <= xcnt_q;
    end else if (cmd.tap_read) begin
      col_addr  <= (col_addr == BA_W'(BUF_DEPTH - 1)) ? '0 : col_addr + 1'b1;
      cols_left <= cols_left - 1'b1;
    end
  end

  // Pixel store: one write port for mapped pixels, one registered read port.
  logic [PIX_W-1:0] pix_mem [BUF_DEPTH];
  logic [PIX_W-1:0] rd_q;
  logic [BA_W-1:0]  rd_addr;

  assign rd_addr = cmd.center_read ? out_addr : col_addr;

  always_ff @(posedge clk) begin
    if (cmd.pix_write) begin
      pix_mem[in_addr] <= tone_q;
    end
    if (cmd.tap_read || cmd.center_read) begin
      rd_q <= pix_mem[rd_addr];
    end
  end

  // Horizontal and vertical sums.
  logic tap_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_valid <= 1'b0;
    end else begin
      tap_valid <= cmd.tap_read;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.row_begin) begin
      hsum <= '0;
    end else if (tap_valid) begin
      hsum <= hsum + SUM_W'(rd_q);
    end
    if (cmd.setup_rows) begin
      vsum <= '0;
    end else if (cmd.row_end) begin
      vsum <= vsum + SUM_W'(div_quo);
    end
  end

  // Sharpening: mapped * 256 + amount * (mapped - blur), in 8.8.
  logic signed [AMT_W:0]    amt_s;
  logic signed [PIX_W:0]    diff_s;
  logic signed [PROD_W-1:0] prod_s;
  logic signed [T_W-1:0]    t_q;
  logic [T_W-1:0]           t_round;
  logic [PIX_W-1:0]         sat;

  assign amt_s  = signed'({1'b0, sharpen_amount});
  assign diff_s = signed'({1'b0, rd_q}) - signed'({1'b0, PIX_W'(div_quo)});
  assign prod_s = amt_s * diff_s;

  always_ff @(posedge clk) begin
    if (cmd.mult) begin
      t_q <= T_W'(prod_s) + T_W'(signed'({1'b0, rd_q, 8'h00}));
    end
  end

  // Round half up and saturate to the pixel range.
  assign t_round = T_W'(t_q) + T_W'(128);

  always_comb begin
    if (t_q <= 0) begin
      sat = '0;
    end else if (t_q >= T_SAT) begin
      sat = PIX_MAX;
    end else begin
      sat = t_round[15:8];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      pixel_out <= sat;
      frame_end <= last_out;
    end
  end

  // Status back to the controller.
  logic [CNT_W-1:0] gap;

  assign gap = ic - oc;

  always_comb begin
    status.op       = op_q;
    status.in_full  = (ic >= n_q);
    status.out_all  = (oc >= n_q);
    status.emit_ok  = (oc < n_q) && (ic > oc) && (CMP_W'(gap) > CMP_W'(d_q));
    status.div_busy = div_busy;
    status.div_done = div_done;
    status.col_last = (cols_left == WIN_W'(1));
    status.row_last = (rows_left == WIN_W'(1));
    status.out_free = !out_valid || !out_stall;
  end

endmodule

`default_nettype wire

// File: hw/rtl/lums_controller.sv
// ----------------------------------------------------------------------------
// LUT unsharp mask filter controller
// Sequences item decode, window walk, divisions and result delivery.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lut_unsharp_mask_filter_defines.svh"

module lums_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  lums_pkg::status_t status,
  output lums_pkg::cmd_t    cmd
);

  import lums_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != ST_IDLE);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        unique case (status.op)
          OP_PIXEL: begin
            state_next = status.in_full ? ST_IDLE : ST_PIX_WRITE;
          end
          OP_FLUSH: begin
            if (status.in_full && !status.out_all) begin
              state_next = ST_K_START;
            end else begin
              state_next = ST_IDLE;
            end
          end
          default: state_next = ST_IDLE;
        endcase
      end
      ST_PIX_WRITE: state_next = ST_PIX_CHECK;
      ST_PIX_CHECK: state_next = status.emit_ok ? ST_K_START : ST_IDLE;
      ST_K_START:   state_next = ST_K_WAIT;
      ST_K_WAIT: begin
        if (status.div_done) state_next = ST_SETUP_A;
      end
      ST_SETUP_A:   state_next = ST_SETUP_B;
      ST_SETUP_B:   state_next = ST_SETUP_C;
      ST_SETUP_C:   state_next = ST_ROW_BEGIN;
      ST_ROW_BEGIN: state_next = ST_TAP;
      ST_TAP: begin
        if (status.col_last) state_next = ST_DRAIN;
      end
      ST_DRAIN:     state_next = ST_H_START;
      ST_H_START:   state_next = ST_H_WAIT;
      ST_H_WAIT: begin
        if (status.div_done) state_next = ST_ROW_END;
      end
      ST_ROW_END:   state_next = status.row_last ? ST_V_START : ST_ROW_BEGIN;
      ST_V_START:   state_next = ST_V_WAIT;
      ST_V_WAIT: begin
        if (status.div_done) state_next = ST_CENTER;
      end
      ST_CENTER:    state_next = ST_MULT;
      ST_MULT:      state_next = ST_RESULT;
      ST_RESULT: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default:      state_next = ST_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd = '0;
    cmd.div_sel = DIV_SEL_POS;
    unique case (state)
      ST_IDLE: cmd.load_item = in_valid;
      ST_DECODE: begin
        cmd.tone_wr      = (status.op == OP_TABLE_WRITE);
        cmd.clear_counts = (status.op == OP_FLUSH) && status.in_full && status.out_all;
      end
      ST_PIX_WRITE: cmd.pix_write = 1'b1;
      ST_K_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_SEL_POS;
      end
      ST_SETUP_A:   cmd.setup_bounds = 1'b1;
      ST_SETUP_B:   cmd.setup_offset = 1'b1;
      ST_SETUP_C:   cmd.setup_rows   = 1'b1;
      ST_ROW_BEGIN: cmd.row_begin    = 1'b1;
      ST_TAP:       cmd.tap_read     = 1'b1;
      ST_H_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_SEL_ROW;
      end
      ST_H_WAIT:    cmd.div_sel = DIV_SEL_ROW;
      ST_ROW_END:   cmd.row_end = 1'b1;
      ST_V_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_SEL_COL;
      end
      ST_V_WAIT:    cmd.div_sel     = DIV_SEL_COL;
      ST_CENTER:    cmd.center_read = 1'b1;
      ST_MULT:      cmd.mult        = 1'b1;
      ST_RESULT:    cmd.out_load    = status.out_free;
      default: ;
    endcase
  end

  // An accepted item is always decoded in the following cycle.
  `LUMS_ASSERT_NEXT(a_accept_decode, clk, rst, in_valid && !in_stall, state == ST_DECODE, "accepted item not decoded")
  // A result is loaded only when the output register can take it.
  `LUMS_ASSERT_IMPLY(a_load_free, clk, rst, cmd.out_load, status.out_free, "result overwrote a pending beat")
  // The shared divider is never restarted while it is still working.
  `LUMS_ASSERT_IMPLY(a_div_idle, clk, rst, cmd.div_start, !status.div_busy, "divider restarted while busy")

endmodule

`default_nettype wire

// File: hw/rtl/lut_unsharp_mask_filter.sv
// ----------------------------------------------------------------------------
// LUT unsharp mask filter
// Tone maps a raster pixel stream through a loadable table and sharpens it
// with an unsharp mask built on a separable, edge-cut box blur.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (in_valid/in_stall) carry an operation: a tone table write,
//   a raw pixel, or a flush that drains one pending output. A pixel beat
//   returns the output R*W+R places earlier once that much of the frame is
//   in; flush beats return the rest after the frame is complete. Output
//   beats (out_valid/out_stall) carry pixel_out and frame_end, high on the
//   last pixel of the frame. Registers are to be written by the user on the
//   cfg channel only while the block is idle; the block does not enforce
//   this. cfg_ready is always high. One item is in work at a time.
//   A returned pixel walks a window of rows by cols, the window extents
//   (up to 2R+1): the walk reads one tap per cycle through the pixel
//   store's read port, and a shared restoring divider works out the
//   position and every average.
//   The output register holds a finished beat while the next item is taken;
//   a stalled receiver holds the block only when a second result is ready.
//   Reset restores the register defaults and clears the frame counters; the
//   tone table and pixel store hold no reset state.
// ----------------------------------------------------------------------------
`default_nettype none

module lut_unsharp_mask_filter #(
  parameter int MAX_WIDTH  = lums_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = lums_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_RADIUS = lums_pkg::MAX_RADIUS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [lums_pkg::OP_W-1:0]        operation,
  input  logic [lums_pkg::PIX_W-1:0]       table_index,
  input  logic [lums_pkg::PIX_W-1:0]       table_value,
  input  logic [lums_pkg::PIX_W-1:0]       pixel_in,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [lums_pkg::PIX_W-1:0]       pixel_out,
  output logic                             frame_end,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lums_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lums_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import lums_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer.
  lums_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Storage and arithmetic.
  lums_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .operation   (operation),
    .table_index (table_index),
    .table_value (table_value),
    .pixel_in    (pixel_in),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_out   (pixel_out),
    .frame_end   (frame_end),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// Testbench for the LUT unsharp mask filter
// Drives table writes, pixels, flushes and no-ops under random idling on both
// channels, predicts every returned beat with an in-bench tone map and
// box-blur sharpen calculation, and checks each beat field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lums_pkg::*;

  localparam int MAX_W      = 1024;
  localparam int MAX_H      = 1024;
  localparam int MAX_R      = 8;
  localparam int STORE_SIZE = (2 * MAX_R + 1) * MAX_W + 2 * MAX_R + 1;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int ITEM_GOAL  = 400;
  localparam int SETTLE     = 64;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             fe;
  } beat_t;

  typedef struct packed {
    op_t              op;
    logic [PIX_W-1:0] idx;
    logic [PIX_W-1:0] val;
    logic [PIX_W-1:0] pix;
    bit               typed;
    logic [PIX_W-1:0] exp_pix;
    logic             exp_fe;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [OP_W-1:0] operation = OP_NOP;
  logic [PIX_W-1:0] table_index = '0;
  logic [PIX_W-1:0] table_value = '0;
  logic [PIX_W-1:0] pixel_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [PIX_W-1:0] pixel_out;
  logic frame_end;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  lut_unsharp_mask_filter dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .table_index(table_index),
    .table_value(table_value), .pixel_in(pixel_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .pixel_out(pixel_out), .frame_end(frame_end),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Clock with a 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mirror of the block's state, kept by the sharpen predictor.
  logic [PIX_W-1:0] tone_map [TABLE_ENTRIES];
  logic [PIX_W-1:0] pix_store [STORE_SIZE];
  logic [PIX_W-1:0] loaded_codes [$];
  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;
  logic [RAD_W-1:0] radius_reg;
  logic [AMT_W-1:0] amount_reg;
  int unsigned pixels_in;
  int unsigned pixels_out;

  beat_t expected_beats [$];
  int errors = 0;
  int sender_idle = 0;
  int recv_stall = 0;
  int items_sent = 0;
  int cycles = 0;

  function automatic int unsigned clampu(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned eff_width();
    return clampu(width_reg, MAX_W);
  endfunction

  function automatic int unsigned eff_height();
    return clampu(height_reg, MAX_H);
  endfunction

  function automatic int unsigned eff_radius();
    return clampu(radius_reg, MAX_R);
  endfunction

  function automatic int unsigned stored_pix(int unsigned row, int unsigned col,
                                             int unsigned w);
    return pix_store[(row * w + col) % STORE_SIZE];
  endfunction

  // Random byte for fields that the operation ignores.
  function automatic logic [PIX_W-1:0] rand_byte();
    return PIX_W'($urandom);
  endfunction

  // Sharpened value of raster position k: box blur cut at the edges, then
  // mapped + amount * (mapped - blur) in 8.8, rounded half up and saturated.
  function automatic logic [PIX_W-1:0] sharpen_at(int unsigned k);
    int unsigned w, h, r, y, x, y0, y1, x0, x1, vsum, hsum, blur, center;
    int t;
    w = eff_width();
    h = eff_height();
    r = eff_radius();
    y = k / w;
    x = k % w;
    vsum = 0;
    if (y >= h) y = h - 1;
    y0 = (y >= r) ? y - r : 0;
    y1 = (y + r >= h) ? h - 1 : y + r;
    x0 = (x >= r) ? x - r : 0;
    x1 = (x + r >= w) ? w - 1 : x + r;
    for (int unsigned yy = y0; yy <= y1; yy++) begin
      hsum = 0;
      for (int unsigned xx = x0; xx <= x1; xx++) hsum += stored_pix(yy, xx, w);
      vsum += hsum / (x1 - x0 + 1);
    end
    blur = vsum / (y1 - y0 + 1);
    center = stored_pix(y, x, w);
    t = int'(center) * 256 + int'(amount_reg) * (int'(center) - int'(blur));
    if (t <= 0) return '0;
    if (t >= 255 * 256) return PIX_MAX;
    return PIX_W'((t + 128) >>> 8);
  endfunction

  function automatic beat_t next_sharpened();
    beat_t b;
    int unsigned k;
    k = pixels_out;
    b.pix = sharpen_at(k);
    b.fe = 1'b0;
    pixels_out++;
    if (k + 1 >= eff_width() * eff_height()) begin
      b.fe = 1'b1;
      pixels_in = 0;
      pixels_out = 0;
    end
    return b;
  endfunction

  // Advances the mirror by one accepted item; got says whether a beat results.
  task automatic predict_item(input op_t op, input logic [PIX_W-1:0] idx,
                              input logic [PIX_W-1:0] val,
                              input logic [PIX_W-1:0] pix,
                              output bit got, output beat_t b);
    int unsigned n, d;
    n = eff_width() * eff_height();
    d = eff_radius() * eff_width() + eff_radius();
    got = 0;
    b = '0;
    case (op)
      OP_TABLE_WRITE: begin
        tone_map[idx] = val;
        loaded_codes.push_back(idx);
      end
      OP_PIXEL: begin
        if (pixels_in < n) begin
          pix_store[pixels_in % STORE_SIZE] = tone_map[pix];
          pixels_in++;
          if (pixels_out < n && pixels_in > pixels_out && pixels_in - pixels_out > d) begin
            got = 1;
            b = next_sharpened();
          end
        end
      end
      OP_FLUSH: begin
        if (pixels_in >= n) begin
          if (pixels_out < n) begin
            got = 1;
            b = next_sharpened();
          end else begin
            pixels_in = 0;
            pixels_out = 0;
          end
        end
      end
      default: ;
    endcase
  endtask

  // Sends one beat, idling first at the current rate, and waits for it to
  // be taken. Stall is sampled at the falling edge before the taking edge.
  task automatic send_beat(input op_t op, input logic [PIX_W-1:0] idx,
                           input logic [PIX_W-1:0] val, input logic [PIX_W-1:0] pix,
                           output bit got, output beat_t b);
    bit ok;
    while ($urandom_range(99) < sender_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    table_index <= idx;
    table_value <= val;
    pixel_in <= pix;
    do begin
      @(negedge clk);
      ok = !in_stall;
      @(posedge clk);
    end while (!ok);
    items_sent++;
    predict_item(op, idx, val, pix, got, b);
  endtask

  task automatic send_checked(input op_t op, input logic [PIX_W-1:0] idx,
                              input logic [PIX_W-1:0] val, input logic [PIX_W-1:0] pix);
    bit got;
    beat_t b;
    send_beat(op, idx, val, pix, got, b);
    if (got) expected_beats.push_back(b);
  endtask

  // Holds the sender until every expected beat is back, then lets the
  // block settle so a register write finds it idle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    bit ok;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do begin
      @(negedge clk);
      ok = cfg_ready;
      @(posedge clk);
    end while (!ok);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_IMAGE_WIDTH:    width_reg = data[DIM_W-1:0];
      CFG_IMAGE_HEIGHT:   height_reg = data[DIM_W-1:0];
      CFG_BLUR_RADIUS:    radius_reg = data[RAD_W-1:0];
      CFG_SHARPEN_AMOUNT: amount_reg = data[AMT_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [PIX_W-1:0] loaded_code();
    return loaded_codes[$urandom_range(loaded_codes.size() - 1)];
  endfunction

  // One frame of random content with some noise mixed in, flushed out.
  task automatic run_frame();
    int unsigned n;
    int unsigned sel;
    n = eff_width() * eff_height();
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(99) < 10) begin
        sel = $urandom_range(2);
        if (sel == 0) send_checked(OP_NOP, rand_byte(), rand_byte(), rand_byte());
        else if (sel == 1) send_checked(OP_TABLE_WRITE, rand_byte(), rand_byte(), rand_byte());
        else send_checked(OP_FLUSH, rand_byte(), rand_byte(), rand_byte());
      end
      send_checked(OP_PIXEL, rand_byte(), rand_byte(), loaded_code());
    end
    if ($urandom_range(99) < 15) send_checked(OP_PIXEL, rand_byte(), rand_byte(), loaded_code());
    while (pixels_in != 0) send_checked(OP_FLUSH, rand_byte(), rand_byte(), rand_byte());
    if ($urandom_range(99) < 10) send_checked(OP_FLUSH, rand_byte(), rand_byte(), rand_byte());
  endtask

  // Directed rows on a 2x2 frame, radius 1, no gain: every beat is the
  // mapped pixel itself.
  row_t directed [] = '{
    '{OP_TABLE_WRITE, 8'h00, 8'hFF, 8'h00, 1'b0, 8'h00, 1'b0},
    '{OP_TABLE_WRITE, 8'hFF, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0},
    '{OP_TABLE_WRITE, 8'hAA, 8'h55, 8'h00, 1'b0, 8'h00, 1'b0},
    '{OP_TABLE_WRITE, 8'h55, 8'hAA, 8'h00, 1'b0, 8'h00, 1'b0},
    '{OP_NOP,         8'hFF, 8'hFF, 8'hFF, 1'b0, 8'h00, 1'b0},
    '{OP_PIXEL,       8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0},
    '{OP_FLUSH,       8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0},
    '{OP_PIXEL,       8'h00, 8'h00, 8'hFF, 1'b0, 8'h00, 1'b0},
    '{OP_PIXEL,       8'h00, 8'h00, 8'hAA, 1'b0, 8'h00, 1'b0},
    '{OP_PIXEL,       8'h00, 8'h00, 8'h55, 1'b1, 8'hFF, 1'b0},
    '{OP_PIXEL,       8'h00, 8'h00, 8'hFF, 1'b0, 8'h00, 1'b0},
    '{OP_FLUSH,       8'h00, 8'h00, 8'h00, 1'b1, 8'h00, 1'b0},
    '{OP_FLUSH,       8'h00, 8'h00, 8'h00, 1'b1, 8'h55, 1'b0},
    '{OP_FLUSH,       8'h00, 8'h00, 8'h00, 1'b1, 8'hAA, 1'b1},
    '{OP_FLUSH,       8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0}
  };

  // Receiver stall, redrawn every cycle.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall);
  end

  // Output beats are checked at the falling edge before the taking edge.
  always @(negedge clk) begin
    beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_beats.size() == 0) begin
        $error("unexpected beat: pixel_out %0d frame_end %0d", pixel_out, frame_end);
        errors++;
      end else begin
        want = expected_beats.pop_front();
        if (pixel_out !== want.pix) begin
          $error("pixel_out: expected %0d, got %0d", want.pix, pixel_out);
          errors++;
        end
        if (frame_end !== want.fe) begin
          $error("frame_end: expected %0d, got %0d", want.fe, frame_end);
          errors++;
        end
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    bit got;
    beat_t b;
    int phase;
    width_reg = WIDTH_RESET;
    height_reg = HEIGHT_RESET;
    radius_reg = RADIUS_RESET;
    amount_reg = AMOUNT_RESET;
    pixels_in = 0;
    pixels_out = 0;
    sender_idle = 21;
    recv_stall = 84;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_reg(CFG_IMAGE_WIDTH, 12'd2);
    write_reg(CFG_IMAGE_HEIGHT, 12'd2);
    write_reg(CFG_BLUR_RADIUS, 12'd1);
    write_reg(CFG_SHARPEN_AMOUNT, 12'd0);

    // Directed table: typed rows override the predicted beat.
    foreach (directed[i]) begin
      send_beat(directed[i].op, directed[i].idx, directed[i].val, directed[i].pix, got, b);
      if (directed[i].typed) begin
        b.pix = directed[i].exp_pix;
        b.fe = directed[i].exp_fe;
      end
      if (got || directed[i].typed) expected_beats.push_back(b);
    end

    // Stale counts: one beat out of a 2x2 frame, then the frame shrinks to
    // a single pixel and a flush just clears the counters.
    for (int i = 0; i < 4; i++) send_checked(OP_PIXEL, 8'h00, 8'h00, 8'hAA);
    wait_drained();
    write_reg(CFG_IMAGE_WIDTH, 12'd1);
    write_reg(CFG_IMAGE_HEIGHT, 12'd1);
    send_checked(OP_FLUSH, 8'h00, 8'h00, 8'h00);

    // Random frames across register settings and idling modes.
    phase = 0;
    while (items_sent < ITEM_GOAL) begin
      wait_drained();
      if (items_sent < ITEM_GOAL / 3) begin
        sender_idle = 21;
        recv_stall = 84;
      end else if (items_sent < 2 * ITEM_GOAL / 3) begin
        sender_idle = 84;
        recv_stall = 21;
      end else begin
        sender_idle = 0;
        recv_stall = 0;
      end
      if (phase == 3) begin
        // Largest radius and gain register values; the radius is clamped.
        write_reg(CFG_IMAGE_WIDTH, 12'd8);
        write_reg(CFG_IMAGE_HEIGHT, 12'd6);
        write_reg(CFG_BLUR_RADIUS, 12'hF);
        write_reg(CFG_SHARPEN_AMOUNT, 12'hFFF);
      end else begin
        write_reg(CFG_IMAGE_WIDTH,
                  ($urandom_range(9) == 0) ? 12'd0 : CFG_DATA_W'($urandom_range(1, 8)));
        write_reg(CFG_IMAGE_HEIGHT,
                  ($urandom_range(9) == 0) ? 12'd0 : CFG_DATA_W'($urandom_range(1, 6)));
        write_reg(CFG_BLUR_RADIUS, CFG_DATA_W'($urandom_range(0, 15)));
        case ($urandom_range(3))
          0: write_reg(CFG_SHARPEN_AMOUNT, 12'd0);
          1: write_reg(CFG_SHARPEN_AMOUNT, 12'hFFF);
          default: write_reg(CFG_SHARPEN_AMOUNT, CFG_DATA_W'($urandom));
        endcase
        if ($urandom_range(9) == 0) begin
          write_reg(CFG_IDX_W'($urandom_range(4, 7)), CFG_DATA_W'($urandom));
        end
      end
      run_frame();
      phase++;
    end

    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
+incdir+hw/rtl
hw/rtl/lums_pkg.sv
hw/rtl/lums_divider.sv
hw/rtl/lums_datapath.sv
hw/rtl/lums_controller.sv
hw/rtl/lut_unsharp_mask_filter.sv
tb/tb_top.sv
